// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands on clk and the active low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define LSTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define LSTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/lstc_pkg.sv -----
// ----------------------------------------------------------------------------
// lstc_pkg
// Shared types, trigger slot codes and mask helpers for the load switch
// trigger controller.
// ----------------------------------------------------------------------------
package lstc_pkg;

  // Sizing
  localparam int CHANNELS   = 8;
  localparam int DELAY_BITS = 16;
  localparam int MASK_W     = 8;
  localparam int CFG_DLY_W  = 16;
  localparam int TRG_IDX_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DLY_CMP_W  = (DELAY_BITS > CFG_DLY_W) ? DELAY_BITS : CFG_DLY_W;

  localparam logic [MASK_W-1:0]     CH_MASK = MASK_W'((1 << CHANNELS) - 1);
  localparam logic [DELAY_BITS-1:0] CNT_MAX = '1;

  // Event forced output bits
  localparam int LED_BIT = 7;
  localparam int AUX_BIT = 6;

  // Register reset values
  localparam logic [CFG_DLY_W-1:0] DLY_RST      = CFG_DLY_W'(30000);
  localparam logic [MASK_W-1:0]    ZONE_PAT_RST = 8'hF0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_DLY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_DLY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_PAT = 2'd2;

  // Trigger slots
  localparam logic [TRG_IDX_W-1:0] TRG_MAIN_ON     = 6'd0;
  localparam logic [TRG_IDX_W-1:0] TRG_MAIN_OFF    = 6'd1;
  localparam logic [TRG_IDX_W-1:0] TRG_OUT_ALL_ON  = 6'd2;
  localparam logic [TRG_IDX_W-1:0] TRG_OUT_ALL_OFF = 6'd3;
  localparam logic [TRG_IDX_W-1:0] TRG_AMP_ON      = 6'd28;
  localparam logic [TRG_IDX_W-1:0] TRG_AMP_OFF     = 6'd29;
  localparam logic [TRG_IDX_W-1:0] TRG_AMP_ALL_ON  = 6'd30;
  localparam logic [TRG_IDX_W-1:0] TRG_AMP_ALL_OFF = 6'd31;
  localparam logic [TRG_IDX_W-1:0] TRG_ZONE_ON     = 6'd56;
  localparam logic [TRG_IDX_W-1:0] TRG_ZONE_OFF    = 6'd57;
  localparam logic [TRG_IDX_W-1:0] TRG_ZONE_TOGGLE = 6'd58;
  // Per channel bit triggers: base + 3*n is on, +1 off, +2 toggle
  localparam int TRG_OUT_BIT_BASE = 4;
  localparam int TRG_AMP_BIT_BASE = 32;

  // Relay sequencer command
  typedef enum logic [1:0] {
    CMD_NONE = 2'b00,
    CMD_ON   = 2'b01,
    CMD_OFF  = 2'b10
  } cmd_t;

  // Zone macro operation
  typedef enum logic [1:0] {
    ZONE_NONE   = 2'b00,
    ZONE_ON     = 2'b01,
    ZONE_OFF    = 2'b10,
    ZONE_TOGGLE = 2'b11
  } zone_op_t;

  typedef struct packed {
    logic              all_on;
    logic              all_off;
    logic [MASK_W-1:0] set_bits;
    logic [MASK_W-1:0] clr_bits;
    logic [MASK_W-1:0] tog_bits;
  } mask_edit_t;

  typedef struct packed {
    cmd_t       main_cmd;
    cmd_t       amp_cmd;
    mask_edit_t out_edit;
    mask_edit_t amp_edit;
    zone_op_t   zone_op;
  } trig_dec_t;

  // Sequencer control for one pass
  typedef struct packed {
    logic step;
    cmd_t trg_cmd;
    cmd_t chg_cmd;
    logic tick;
  } seq_ctrl_t;

  typedef struct packed {
    logic                 trigger_valid;
    logic [TRG_IDX_W-1:0] trigger_index;
    logic                 supply_event;
    logic                 led_event;
    logic                 amp_event;
    logic                 aux_event;
    logic                 ms_tick;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] output_mask;
    logic [MASK_W-1:0] amp_standby_mask;
    logic              main_relay;
    logic              amp_relay;
    logic              zone_active;
  } out_item_t;

  // Apply one decoded edit to a mask
  function automatic logic [MASK_W-1:0] mask_edit(input logic [MASK_W-1:0] m,
                                                  input mask_edit_t e);
    logic [MASK_W-1:0] r;
    if (e.all_on) begin
      r = CH_MASK;
    end else if (e.all_off) begin
      r = '0;
    end else begin
      r = ((m | e.set_bits) & ~e.clr_bits) ^ e.tog_bits;
    end
    return r;
  endfunction

endpackage

// ----- sv/lstc_trigger_decode.sv -----
// ----------------------------------------------------------------------------
// lstc_trigger_decode
// Turns a trigger slot index into relay commands, mask edits and a zone
// macro operation.
// ----------------------------------------------------------------------------
module lstc_trigger_decode (
  input  logic                          trigger_valid,
  input  logic [lstc_pkg::TRG_IDX_W-1:0] trigger_index,
  output lstc_pkg::trig_dec_t           dec
);

  always_comb begin
    dec          = '0;
    dec.main_cmd = lstc_pkg::CMD_NONE;
    dec.amp_cmd  = lstc_pkg::CMD_NONE;
    dec.zone_op  = lstc_pkg::ZONE_NONE;
    if (trigger_valid) begin
      // Single slots
      unique case (trigger_index)
        lstc_pkg::TRG_MAIN_ON:     dec.main_cmd = lstc_pkg::CMD_ON;
        lstc_pkg::TRG_MAIN_OFF:    dec.main_cmd = lstc_pkg::CMD_OFF;
        lstc_pkg::TRG_OUT_ALL_ON:  dec.out_edit.all_on = 1'b1;
        lstc_pkg::TRG_OUT_ALL_OFF: dec.out_edit.all_off = 1'b1;
        lstc_pkg::TRG_AMP_ON:      dec.amp_cmd = lstc_pkg::CMD_ON;
        lstc_pkg::TRG_AMP_OFF:     dec.amp_cmd = lstc_pkg::CMD_OFF;
        lstc_pkg::TRG_AMP_ALL_ON:  dec.amp_edit.all_on = 1'b1;
        lstc_pkg::TRG_AMP_ALL_OFF: dec.amp_edit.all_off = 1'b1;
        lstc_pkg::TRG_ZONE_ON:     dec.zone_op = lstc_pkg::ZONE_ON;
        lstc_pkg::TRG_ZONE_OFF:    dec.zone_op = lstc_pkg::ZONE_OFF;
        lstc_pkg::TRG_ZONE_TOGGLE: dec.zone_op = lstc_pkg::ZONE_TOGGLE;
        default: ;
      endcase

      // Per channel on / off / toggle; channels past CHANNELS never match
      for (int n = 0; n < lstc_pkg::CHANNELS; n++) begin
        if (trigger_index == lstc_pkg::TRG_IDX_W'(lstc_pkg::TRG_OUT_BIT_BASE + 3*n))
          dec.out_edit.set_bits[n] = 1'b1;
        if (trigger_index == lstc_pkg::TRG_IDX_W'(lstc_pkg::TRG_OUT_BIT_BASE + 3*n + 1))
          dec.out_edit.clr_bits[n] = 1'b1;
        if (trigger_index == lstc_pkg::TRG_IDX_W'(lstc_pkg::TRG_OUT_BIT_BASE + 3*n + 2))
          dec.out_edit.tog_bits[n] = 1'b1;
        if (trigger_index == lstc_pkg::TRG_IDX_W'(lstc_pkg::TRG_AMP_BIT_BASE + 3*n))
          dec.amp_edit.set_bits[n] = 1'b1;
        if (trigger_index == lstc_pkg::TRG_IDX_W'(lstc_pkg::TRG_AMP_BIT_BASE + 3*n + 1))
          dec.amp_edit.clr_bits[n] = 1'b1;
        if (trigger_index == lstc_pkg::TRG_IDX_W'(lstc_pkg::TRG_AMP_BIT_BASE + 3*n + 2))
          dec.amp_edit.tog_bits[n] = 1'b1;
      end
    end
  end

endmodule

// ----- sv/lstc_sequencer.sv -----
// ----------------------------------------------------------------------------
// lstc_sequencer
// Relay sequencer: closes at once on an on command, opens after an off delay
// counted in millisecond ticks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lstc_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lstc_pkg::seq_ctrl_t            ctrl,
  input  logic [lstc_pkg::CFG_DLY_W-1:0] delay,
  output logic                           closed
);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_ON      = 4'b0010,
    PH_TURNOFF = 4'b0100,
    PH_OFF     = 4'b1000
  } phase_t;

  phase_t                            phase_r, phase_nxt, phase_trg, phase_stp;
  logic [lstc_pkg::DELAY_BITS-1:0]   elapsed_r, elapsed_nxt;
  logic                              closed_r, closed_nxt;
  logic [lstc_pkg::DLY_CMP_W-1:0]    lim;

  // Delay clamped to the counter range
  always_comb begin
    if (lstc_pkg::DLY_CMP_W'(delay) > lstc_pkg::DLY_CMP_W'(lstc_pkg::CNT_MAX)) begin
      lim = lstc_pkg::DLY_CMP_W'(lstc_pkg::CNT_MAX);
    end else begin
      lim = lstc_pkg::DLY_CMP_W'(delay);
    end
  end

  // Trigger command, one sequencer step, then change detection override
  always_comb begin
    unique case (ctrl.trg_cmd)
      lstc_pkg::CMD_ON:  phase_trg = PH_ON;
      lstc_pkg::CMD_OFF: phase_trg = PH_TURNOFF;
      default:           phase_trg = phase_r;
    endcase

    phase_stp   = PH_IDLE;
    elapsed_nxt = elapsed_r;
    closed_nxt  = closed_r;
    unique case (phase_trg)
      PH_ON: begin
        closed_nxt  = 1'b1;
        elapsed_nxt = '0;
      end
      PH_TURNOFF: begin
        phase_stp = PH_TURNOFF;
        if (ctrl.tick && (elapsed_r != lstc_pkg::CNT_MAX))
          elapsed_nxt = elapsed_r + 1'b1;
        if (lstc_pkg::DLY_CMP_W'(elapsed_nxt) >= lim)
          phase_stp = PH_OFF;
      end
      PH_OFF: begin
        closed_nxt  = 1'b0;
        elapsed_nxt = '0;
      end
      default: begin
        elapsed_nxt = '0;
      end
    endcase

    unique case (ctrl.chg_cmd)
      lstc_pkg::CMD_ON:  phase_nxt = PH_ON;
      lstc_pkg::CMD_OFF: phase_nxt = PH_TURNOFF;
      default:           phase_nxt = phase_stp;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      closed_r  <= 1'b0;
    end else if (ctrl.step) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      closed_r  <= closed_nxt;
    end
  end

  // Relay position after this pass
  assign closed = closed_nxt;

  // The relay only closes on a step that carries out an on phase
  `LSTC_ASSERT(a_close_from_on, $rose(closed_r) |-> $past(ctrl.step && phase_trg == PH_ON), "relay closed without an on phase")

endmodule

// ----- sv/load_switch_trigger_controller.sv -----
// ----------------------------------------------------------------------------
// load_switch_trigger_controller
// Trigger driven load switch and amp channel controller with two delayed
// off relay sequencers.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one control pass per transfer (trigger, event levels, ms tick).
//   out_* : one result per pass: both masks, both relay positions and the
//           zone macro state.
//   cfg_* : register writes (0 main off delay, 1 amp off delay, 2 zone
//           pattern); cfg_ready is always high, write only while idle.
// Timing:
//   A pass is worked out in the cycle it is taken and its result is held in
//   the output register from the next cycle; one pass per cycle is taken
//   while in_stall is low. The pass logic is a trigger decode, a mask edit,
//   a change compare and a relay counter step, all between the input port
//   and the output register. A relay trigger acts in the pass that issues it;
//   a detected change acts on the relay from the next pass.
// Reset:
//   rst_n low clears the masks, relays, zone state and counters and loads
//   the register defaults (30000 ms delays, zone pattern 0xF0).
// Stall:
//   While out_stall holds a waiting result, in_stall is raised and the
//   result is held; a new pass is taken in the same cycle the result leaves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module load_switch_trigger_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lstc_pkg::in_item_t              in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output lstc_pkg::out_item_t             out_data,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lstc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lstc_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [lstc_pkg::CFG_DLY_W-1:0] main_dly_r, amp_dly_r;
  logic [lstc_pkg::MASK_W-1:0]    zone_pat_r;

  // Pass state
  logic [lstc_pkg::MASK_W-1:0] out_bits_r, out_bits_nxt, out_seen_r, out_seen_nxt;
  logic [lstc_pkg::MASK_W-1:0] amp_bits_r, amp_bits_nxt, amp_seen_r, amp_seen_nxt;
  logic                        supply_seen_r, supply_seen_nxt;
  logic                        ampev_seen_r, ampev_seen_nxt;
  logic                        zone_on_r, zone_on_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  lstc_pkg::out_item_t out_data_r, out_data_nxt;

  logic                take;
  lstc_pkg::trig_dec_t dec;
  lstc_pkg::seq_ctrl_t main_ctrl, amp_ctrl;
  lstc_pkg::cmd_t      main_chg, amp_chg;
  logic                main_closed, amp_closed;

  // Handshake: a pass is taken whenever the output register is free or leaving
  assign in_stall  = out_valid_r && out_stall;
  assign take      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_dly_r <= lstc_pkg::DLY_RST;
      amp_dly_r  <= lstc_pkg::DLY_RST;
      zone_pat_r <= lstc_pkg::ZONE_PAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lstc_pkg::REG_MAIN_DLY: main_dly_r <= cfg_data[lstc_pkg::CFG_DLY_W-1:0];
        lstc_pkg::REG_AMP_DLY:  amp_dly_r  <= cfg_data[lstc_pkg::CFG_DLY_W-1:0];
        lstc_pkg::REG_ZONE_PAT: zone_pat_r <= cfg_data[lstc_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Trigger decode
  lstc_trigger_decode u_decode (
    .trigger_valid (in_data.trigger_valid),
    .trigger_index (in_data.trigger_index),
    .dec           (dec)
  );

  // Mask edits, zone macro, event forcing and change detection
  always_comb begin
    logic [lstc_pkg::MASK_W-1:0] out_trg;
    out_trg = lstc_pkg::mask_edit(out_bits_r, dec.out_edit);

    zone_on_nxt = zone_on_r;
    case (dec.zone_op)
      lstc_pkg::ZONE_ON: begin
        amp_bits_nxt = zone_pat_r & lstc_pkg::CH_MASK;
        zone_on_nxt  = 1'b1;
      end
      lstc_pkg::ZONE_OFF: begin
        amp_bits_nxt = '0;
        zone_on_nxt  = 1'b0;
      end
      lstc_pkg::ZONE_TOGGLE: begin
        amp_bits_nxt = zone_on_r ? '0 : (zone_pat_r & lstc_pkg::CH_MASK);
        zone_on_nxt  = !zone_on_r;
      end
      default: begin
        amp_bits_nxt = lstc_pkg::mask_edit(amp_bits_r, dec.amp_edit);
      end
    endcase

    // Event levels force the top two outputs
    out_bits_nxt                   = out_trg;
    out_bits_nxt[lstc_pkg::LED_BIT] = in_data.led_event;
    out_bits_nxt[lstc_pkg::AUX_BIT] = in_data.aux_event;

    // Main side change
    out_seen_nxt    = out_seen_r;
    supply_seen_nxt = supply_seen_r;
    main_chg        = lstc_pkg::CMD_NONE;
    if ((out_seen_r != out_bits_nxt) || (supply_seen_r != in_data.supply_event)) begin
      out_seen_nxt    = out_bits_nxt;
      supply_seen_nxt = in_data.supply_event;
      main_chg = ((out_bits_nxt != '0) || in_data.supply_event) ? lstc_pkg::CMD_ON
                                                                 : lstc_pkg::CMD_OFF;
    end

    // Amp side change
    amp_seen_nxt   = amp_seen_r;
    ampev_seen_nxt = ampev_seen_r;
    amp_chg        = lstc_pkg::CMD_NONE;
    if ((amp_seen_r != amp_bits_nxt) || (ampev_seen_r != in_data.amp_event)) begin
      amp_seen_nxt   = amp_bits_nxt;
      ampev_seen_nxt = in_data.amp_event;
      amp_chg = ((amp_bits_nxt != '0) || in_data.amp_event) ? lstc_pkg::CMD_ON
                                                            : lstc_pkg::CMD_OFF;
    end
  end

  // Relay sequencers
  always_comb begin
    main_ctrl.step    = take;
    main_ctrl.trg_cmd = dec.main_cmd;
    main_ctrl.chg_cmd = main_chg;
    main_ctrl.tick    = in_data.ms_tick;
    amp_ctrl.step     = take;
    amp_ctrl.trg_cmd  = dec.amp_cmd;
    amp_ctrl.chg_cmd  = amp_chg;
    amp_ctrl.tick     = in_data.ms_tick;
  end

  lstc_sequencer u_main_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (main_ctrl),
    .delay  (main_dly_r),
    .closed (main_closed)
  );

  lstc_sequencer u_amp_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (amp_ctrl),
    .delay  (amp_dly_r),
    .closed (amp_closed)
  );

  // State update on each taken pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_bits_r    <= '0;
      out_seen_r    <= '1;
      amp_bits_r    <= '0;
      amp_seen_r    <= '1;
      supply_seen_r <= 1'b0;
      ampev_seen_r  <= 1'b0;
      zone_on_r     <= 1'b0;
    end else if (take) begin
      out_bits_r    <= out_bits_nxt;
      out_seen_r    <= out_seen_nxt;
      amp_bits_r    <= amp_bits_nxt;
      amp_seen_r    <= amp_seen_nxt;
      supply_seen_r <= supply_seen_nxt;
      ampev_seen_r  <= ampev_seen_nxt;
      zone_on_r     <= zone_on_nxt;
    end
  end

  // Result register
  always_comb begin
    out_data_nxt.output_mask      = out_bits_nxt;
    out_data_nxt.amp_standby_mask = amp_bits_nxt;
    out_data_nxt.main_relay       = main_closed;
    out_data_nxt.amp_relay        = amp_closed;
    out_data_nxt.zone_active      = zone_on_nxt;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  `LSTC_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r, "result pending after reset")
  `LSTC_ASSERT(a_take_gives_result, take |=> out_valid_r, "transfer taken without a result")
  `LSTC_ASSERT(a_led_forced, take |=> out_data_r.output_mask[lstc_pkg::LED_BIT] == $past(in_data.led_event), "led output bit not forced")
  `LSTC_ASSERT(a_zone_only_on_pass, $past(rst_n) && !$past(take) |-> $stable(zone_on_r), "zone state changed without a transfer")

endmodule
